### design/mmas_pkg.sv
// Package for the multichannel moving average scaler.
// Holds widths, channel indexes, scaling constants and shared types.
// No dependencies.
`default_nettype none

package mmas_pkg;

    // Frame layout
    localparam int CHANNELS = 9;
    localparam int SAMPLE_W = 12;
    localparam int WINDOW   = 10;   // samples kept per channel, 2..32

    localparam int CH_POWER    = 0;
    localparam int CH_AUX_A    = 1;
    localparam int CH_AUX_B    = 2;
    localparam int CH_PITCH    = 3;
    localparam int CH_YAW      = 4;
    localparam int CH_THROTTLE = 5;
    localparam int CH_AUX_C    = 6;
    localparam int CH_AUX_D    = 7;
    localparam int CH_ROLL     = 8;

    // Running sum holds up to WINDOW full-scale samples
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int SUM_W      = $clog2(WINDOW * SAMPLE_MAX + 1);

    // Mean = sum / WINDOW as an exact reciprocal multiply:
    // m = ceil(2^(N+l) / d), l >= log2(d), exact for all n < 2^N
    localparam int MEAN_SH    = SUM_W + $clog2(WINDOW);
    localparam int MEAN_MUL_W = SUM_W + 1;
    localparam int MEAN_PROD_W = SUM_W + MEAN_MUL_W;
    localparam longint unsigned MEAN_MUL_FULL =
        ((64'd1 << MEAN_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [MEAN_MUL_W-1:0] MEAN_MUL = MEAN_MUL_W'(MEAN_MUL_FULL);

    // Scale factors, reduced: 3535/1405 = 707/281, 1000/4090 = 100/409
    localparam int SCALE_K_W  = 10;
    localparam logic [SCALE_K_W-1:0] POWER_NUM = SCALE_K_W'(707);
    localparam logic [SCALE_K_W-1:0] AUX_NUM   = SCALE_K_W'(100);
    localparam int POWER_DEN = 281;
    localparam int AUX_DEN   = 409;

    localparam int NUM_W     = SAMPLE_W + SCALE_K_W;
    localparam int DEN_L     = 9;   // covers both denominators
    localparam int SCALE_SH  = NUM_W + DEN_L;
    localparam int RECIP_W   = NUM_W + 1;
    localparam int SCALE_PROD_W = NUM_W + RECIP_W;
    localparam longint unsigned POWER_MUL_FULL =
        ((64'd1 << SCALE_SH) + 64'(POWER_DEN) - 64'd1) / 64'(POWER_DEN);
    localparam longint unsigned AUX_MUL_FULL =
        ((64'd1 << SCALE_SH) + 64'(AUX_DEN) - 64'd1) / 64'(AUX_DEN);
    localparam logic [RECIP_W-1:0] POWER_MUL = RECIP_W'(POWER_MUL_FULL);
    localparam logic [RECIP_W-1:0] AUX_MUL   = RECIP_W'(AUX_MUL_FULL);

    // Result widths
    localparam int VALUE_W = 14;
    localparam int AUX_W   = 10;
    localparam int STICK_W = 11;
    localparam logic [VALUE_W-1:0] STICK_BASE = VALUE_W'(1000);

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef sample_t [CHANNELS-1:0] frame_t;
    typedef logic [VALUE_W-1:0] value_t;

    // Stage load strobes shared by all lanes
    typedef struct packed {
        logic ld_sum;
        logic ld_mean;
        logic ld_num;
        logic ld_out;
    } adv_t;

    // Scaling flavor of one lane
    typedef struct packed {
        logic is_power;
        logic is_stick;
    } lane_kind_t;

    function automatic lane_kind_t lane_kind(input int ch);
        lane_kind_t k;
        k.is_power = (ch == CH_POWER);
        k.is_stick = (ch == CH_PITCH) || (ch == CH_YAW) ||
                     (ch == CH_THROTTLE) || (ch == CH_ROLL);
        return k;
    endfunction

endpackage

`default_nettype wire

### design/mmas_in_if.sv
// Input channel: one frame of nine raw converter samples per item.
// Depends on mmas_pkg.
`default_nettype none

interface mmas_in_if import mmas_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_power;
    sample_t sample_aux_a;
    sample_t sample_aux_b;
    sample_t sample_pitch;
    sample_t sample_yaw;
    sample_t sample_throttle;
    sample_t sample_aux_c;
    sample_t sample_aux_d;
    sample_t sample_roll;

    modport source (
        output valid, sample_power, sample_aux_a, sample_aux_b, sample_pitch,
               sample_yaw, sample_throttle, sample_aux_c, sample_aux_d, sample_roll,
        input  ready
    );
    modport sink (
        input  valid, sample_power, sample_aux_a, sample_aux_b, sample_pitch,
               sample_yaw, sample_throttle, sample_aux_c, sample_aux_d, sample_roll,
        output ready
    );
endinterface

`default_nettype wire

### design/mmas_out_if.sv
// Output channel: nine scaled channel values per item.
// Depends on mmas_pkg.
`default_nettype none

interface mmas_out_if import mmas_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] power_value;
    logic [AUX_W-1:0]   aux_a_value;
    logic [AUX_W-1:0]   aux_b_value;
    logic [AUX_W-1:0]   aux_c_value;
    logic [AUX_W-1:0]   aux_d_value;
    logic [STICK_W-1:0] pitch_value;
    logic [STICK_W-1:0] yaw_value;
    logic [STICK_W-1:0] throttle_value;
    logic [STICK_W-1:0] roll_value;

    modport source (
        output valid, power_value, aux_a_value, aux_b_value, aux_c_value,
               aux_d_value, pitch_value, yaw_value, throttle_value, roll_value,
        input  ready
    );
    modport sink (
        input  valid, power_value, aux_a_value, aux_b_value, aux_c_value,
               aux_d_value, pitch_value, yaw_value, throttle_value, roll_value,
        output ready
    );
endinterface

`default_nettype wire

### design/mmas_cell.sv
// One window cell: holds one frame of samples and passes it on to the
// next cell whenever a new frame enters the chain. Depends on mmas_pkg.
`default_nettype none

module mmas_cell
    import mmas_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   shift,
    input  wire frame_t din,
    output frame_t      dout
);

    frame_t frame_reg;

    // window starts out all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else if (shift)
        begin
            frame_reg <= din;
        end
    end

    assign dout = frame_reg;

endmodule

`default_nettype wire

### design/mmas_lane.sv
// One channel's arithmetic: running sum, window mean, scale and offset.
// Stages advance on the strobes in adv_t. Depends on mmas_pkg.
`default_nettype none

module mmas_lane
    import mmas_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire adv_t       adv,
    input  wire lane_kind_t kind,
    input  wire sample_t    sample,
    input  wire sample_t    oldest,
    output value_t          value
);

    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic [MEAN_PROD_W-1:0]  mean_prod;
    sample_t                 mean_reg;
    sample_t                 mean_next;
    logic [NUM_W-1:0]        num_reg;
    logic [NUM_W-1:0]        num_next;
    logic [SCALE_PROD_W-1:0] scale_prod;
    value_t                  value_reg;
    value_t                  value_next;

    // running sum: new sample in, oldest out (never goes negative)
    assign sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (adv.ld_sum)
        begin
            sum_reg <= sum_next;
        end
    end

    // mean by reciprocal multiply, exact truncation
    assign mean_prod = MEAN_PROD_W'(sum_reg) * MEAN_PROD_W'(MEAN_MUL);
    assign mean_next = mean_prod[MEAN_SH +: SAMPLE_W];

    // numerator of the scale
    assign num_next = NUM_W'(mean_reg) * NUM_W'(kind.is_power ? POWER_NUM : AUX_NUM);

    // quotient by reciprocal multiply, stick channels get the base offset
    assign scale_prod = SCALE_PROD_W'(num_reg) *
                        SCALE_PROD_W'(kind.is_power ? POWER_MUL : AUX_MUL);
    assign value_next = scale_prod[SCALE_SH +: VALUE_W] +
                        (kind.is_stick ? STICK_BASE : '0);

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv.ld_mean)
        begin
            mean_reg <= mean_next;
        end
        if (adv.ld_num)
        begin
            num_reg <= num_next;
        end
        if (adv.ld_out)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

### design/multichannel_moving_average_scaler.sv
// Nine-channel boxcar moving average with per-channel scaling.
// Throughput 1 item per cycle while the output is not stalled, set by the
// window cell chain and the running sum registers, which take one frame
// each cycle. Each stage has its own valid, so a bubble lets a new item in
// while a result waits. Reset clears the window cells, running sums and
// stage valids; no clearing pass.
`default_nettype none

module multichannel_moving_average_scaler
    import mmas_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mmas_in_if.sink    samples,
    mmas_out_if.source values
);

    frame_t new_frame;
    frame_t chain [WINDOW];
    value_t lane_value [CHANNELS];
    adv_t   adv;

    logic sum_vld_reg;
    logic mean_vld_reg;
    logic num_vld_reg;
    logic out_vld_reg;
    logic rdy_sum;
    logic rdy_mean;
    logic rdy_num;
    logic rdy_out;
    logic in_acc;

    // stage handshake: a stage can load when empty or when it drains
    assign rdy_out  = !out_vld_reg  || values.ready;
    assign rdy_num  = !num_vld_reg  || rdy_out;
    assign rdy_mean = !mean_vld_reg || rdy_num;
    assign rdy_sum  = !sum_vld_reg  || rdy_mean;

    assign samples.ready = rdy_sum;
    assign in_acc        = samples.valid && rdy_sum;

    assign adv.ld_sum  = in_acc;
    assign adv.ld_mean = sum_vld_reg  && rdy_mean;
    assign adv.ld_num  = mean_vld_reg && rdy_num;
    assign adv.ld_out  = num_vld_reg  && rdy_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_vld_reg  <= 1'b0;
            mean_vld_reg <= 1'b0;
            num_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (rdy_sum)  sum_vld_reg  <= samples.valid;
            if (rdy_mean) mean_vld_reg <= sum_vld_reg;
            if (rdy_num)  num_vld_reg  <= mean_vld_reg;
            if (rdy_out)  out_vld_reg  <= num_vld_reg;
        end
    end

    // incoming frame in channel order
    assign new_frame[CH_POWER]    = samples.sample_power;
    assign new_frame[CH_AUX_A]    = samples.sample_aux_a;
    assign new_frame[CH_AUX_B]    = samples.sample_aux_b;
    assign new_frame[CH_PITCH]    = samples.sample_pitch;
    assign new_frame[CH_YAW]      = samples.sample_yaw;
    assign new_frame[CH_THROTTLE] = samples.sample_throttle;
    assign new_frame[CH_AUX_C]    = samples.sample_aux_c;
    assign new_frame[CH_AUX_D]    = samples.sample_aux_d;
    assign new_frame[CH_ROLL]     = samples.sample_roll;

    // window: chain of cells, last cell holds the oldest frame
    for (genvar k = 0; k < WINDOW; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            mmas_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (in_acc),
                .din   (new_frame),
                .dout  (chain[k])
            );
        end
        else
        begin : g_body
            mmas_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (in_acc),
                .din   (chain[k-1]),
                .dout  (chain[k])
            );
        end
    end

    // per-channel arithmetic
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        mmas_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .adv    (adv),
            .kind   (lane_kind(c)),
            .sample (new_frame[c]),
            .oldest (chain[WINDOW-1][c]),
            .value  (lane_value[c])
        );
    end

    // result item
    assign values.valid          = out_vld_reg;
    assign values.power_value    = lane_value[CH_POWER];
    assign values.aux_a_value    = lane_value[CH_AUX_A][AUX_W-1:0];
    assign values.aux_b_value    = lane_value[CH_AUX_B][AUX_W-1:0];
    assign values.aux_c_value    = lane_value[CH_AUX_C][AUX_W-1:0];
    assign values.aux_d_value    = lane_value[CH_AUX_D][AUX_W-1:0];
    assign values.pitch_value    = lane_value[CH_PITCH][STICK_W-1:0];
    assign values.yaw_value      = lane_value[CH_YAW][STICK_W-1:0];
    assign values.throttle_value = lane_value[CH_THROTTLE][STICK_W-1:0];
    assign values.roll_value     = lane_value[CH_ROLL][STICK_W-1:0];

    // an accepted item always occupies the sum stage next cycle
    a_acc_fills_sum: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> sum_vld_reg)
        else $error("accepted item lost at sum stage");

    // a result only appears after the numerator stage held an item
    a_out_from_num: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(num_vld_reg))
        else $error("result valid without a preceding item");

    // pitch and roll stick results carry the base offset
    a_stick_base: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (values.pitch_value >= STICK_W'(1000)) &&
                        (values.roll_value  >= STICK_W'(1000)))
        else $error("stick value below base offset");

    // power result stays in range
    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (values.power_value <= VALUE_W'(10303)))
        else $error("power value out of range");

endmodule

`default_nettype wire

### dv/multichannel_moving_average_scaler_tb.sv
// Self-checking testbench for the nine-channel moving average scaler. Drives sample frames
// with random gaps and back-pressure and checks every result against a behavioral window
// model or, for typed rows, a fixed result. Depends on mmas_pkg and the channel interfaces.
`timescale 1ns / 100ps

module multichannel_moving_average_scaler_tb;
    import mmas_pkg::*;

    // Scaling constants of the converter channels
    localparam int unsigned PWR_MUL_K = 3535;
    localparam int unsigned PWR_DIV_K = 1405;
    localparam int unsigned KNOB_SPAN = 1000;
    localparam int unsigned ADC_FULL  = 4090;
    localparam int unsigned STICK_OFS = 1000;

    localparam int RANDOM_ITEMS   = 950;
    localparam int MAX_IDLE       = 15;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    // One result item, in port order of the output channel
    typedef struct packed {
        logic [VALUE_W-1:0] power;
        logic [AUX_W-1:0]   aux_a;
        logic [AUX_W-1:0]   aux_b;
        logic [AUX_W-1:0]   aux_c;
        logic [AUX_W-1:0]   aux_d;
        logic [STICK_W-1:0] pitch;
        logic [STICK_W-1:0] yaw;
        logic [STICK_W-1:0] throttle;
        logic [STICK_W-1:0] roll;
    } scaled_t;

    // Directed stimulus row; fixed_result is used only when typed is set
    typedef struct {
        frame_t  frame;
        bit      typed;
        scaled_t fixed_result;
    } stim_row_t;

    localparam scaled_t RESULT_IDLE = '{0, 0, 0, 0, 0, 1000, 1000, 1000, 1000};
    localparam scaled_t RESULT_FULL = '{10303, 1001, 1001, 1001, 1001,
                                        2001, 2001, 2001, 2001};

    logic clk;
    logic rst_n;

    mmas_in_if  samples_bus ();
    mmas_out_if values_bus ();

    multichannel_moving_average_scaler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(samples_bus),
        .values (values_bus)
    );

    // Window model: per-channel history, running sums, write slot
    sample_t     history_window [CHANNELS][WINDOW] = '{default: '0};
    int unsigned history_sum [CHANNELS] = '{default: 0};
    int          history_slot = 0;

    scaled_t expected_values [$];
    int      error_count = 0;
    int      idle_cycles = 0;
    bit      tx_burst = 1'b0;
    bit      rx_burst = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned knob_scale(input int unsigned avg);
        return (avg * KNOB_SPAN) / ADC_FULL;
    endfunction

    // Advance the window model by one frame and scale the new means
    function automatic scaled_t next_scaled_values(input frame_t f);
        int unsigned avg [CHANNELS];
        scaled_t     r;
        for (int c = 0; c < CHANNELS; c++)
        begin
            history_sum[c] = history_sum[c] - history_window[c][history_slot] + f[c];
            history_window[c][history_slot] = f[c];
            avg[c] = history_sum[c] / int'(WINDOW);
        end
        history_slot = (history_slot + 1 == WINDOW) ? 0 : history_slot + 1;

        r.power    = VALUE_W'((avg[CH_POWER] * PWR_MUL_K) / PWR_DIV_K);
        r.aux_a    = AUX_W'(knob_scale(avg[CH_AUX_A]));
        r.aux_b    = AUX_W'(knob_scale(avg[CH_AUX_B]));
        r.aux_c    = AUX_W'(knob_scale(avg[CH_AUX_C]));
        r.aux_d    = AUX_W'(knob_scale(avg[CH_AUX_D]));
        r.pitch    = STICK_W'(STICK_OFS + knob_scale(avg[CH_PITCH]));
        r.yaw      = STICK_W'(STICK_OFS + knob_scale(avg[CH_YAW]));
        r.throttle = STICK_W'(STICK_OFS + knob_scale(avg[CH_THROTTLE]));
        r.roll     = STICK_W'(STICK_OFS + knob_scale(avg[CH_ROLL]));
        return r;
    endfunction

    function automatic frame_t uniform(input sample_t s);
        return {CHANNELS{s}};
    endfunction

    // Even channels get a, odd channels get b
    function automatic frame_t stripes(input sample_t a, input sample_t b);
        frame_t f;
        for (int c = 0; c < CHANNELS; c++)
            f[c] = (c % 2 == 0) ? a : b;
        return f;
    endfunction

    // Offer one frame after a random gap, none in a burst, then record its expected result
    task automatic drive_frame(input frame_t f, input bit typed, input scaled_t fixed_result);
        int      gap;
        scaled_t predicted;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            samples_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_bus.valid           <= 1'b1;
        samples_bus.sample_power    <= f[CH_POWER];
        samples_bus.sample_aux_a    <= f[CH_AUX_A];
        samples_bus.sample_aux_b    <= f[CH_AUX_B];
        samples_bus.sample_pitch    <= f[CH_PITCH];
        samples_bus.sample_yaw      <= f[CH_YAW];
        samples_bus.sample_throttle <= f[CH_THROTTLE];
        samples_bus.sample_aux_c    <= f[CH_AUX_C];
        samples_bus.sample_aux_d    <= f[CH_AUX_D];
        samples_bus.sample_roll     <= f[CH_ROLL];
        do
            @(posedge clk);
        while (!samples_bus.ready);
        // Model always advances; typed rows override its answer
        predicted = next_scaled_values(f);
        expected_values.push_back(typed ? fixed_result : predicted);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        scaled_t want;
        if (rst_n && values_bus.valid && values_bus.ready)
        begin
            if (expected_values.size() == 0)
            begin
                error_count++;
                $display("%0t: result item with no expected value, actual power %0d",
                         $time, values_bus.power_value);
            end
            else
            begin
                want = expected_values.pop_front();
                check_field("power_value",    want.power,    values_bus.power_value);
                check_field("aux_a_value",    want.aux_a,    values_bus.aux_a_value);
                check_field("aux_b_value",    want.aux_b,    values_bus.aux_b_value);
                check_field("aux_c_value",    want.aux_c,    values_bus.aux_c_value);
                check_field("aux_d_value",    want.aux_d,    values_bus.aux_d_value);
                check_field("pitch_value",    want.pitch,    values_bus.pitch_value);
                check_field("yaw_value",      want.yaw,      values_bus.yaw_value);
                check_field("throttle_value", want.throttle, values_bus.throttle_value);
                check_field("roll_value",     want.roll,     values_bus.roll_value);
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((samples_bus.valid && samples_bus.ready) || (values_bus.valid && values_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side back-pressure
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        values_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 40 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                values_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            values_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!values_bus.valid);
            taken++;
        end
    end

    // Reset, directed table, random frames, drain
    initial
    begin
        stim_row_t plan [$];
        frame_t    f;
        sample_t   levels [CHANNELS];
        int        run_left;
        int        run_kind;

        rst_n                       <= 1'b0;
        samples_bus.valid           <= 1'b0;
        samples_bus.sample_power    <= '0;
        samples_bus.sample_aux_a    <= '0;
        samples_bus.sample_aux_b    <= '0;
        samples_bus.sample_pitch    <= '0;
        samples_bus.sample_yaw      <= '0;
        samples_bus.sample_throttle <= '0;
        samples_bus.sample_aux_c    <= '0;
        samples_bus.sample_aux_d    <= '0;
        samples_bus.sample_roll     <= '0;

        // Start-up from the zero window, fill to full scale, stripe and low-level frames, then drain to zero
        plan.push_back('{uniform('0), 1'b1, RESULT_IDLE});
        for (int i = 0; i < WINDOW - 1; i++)
            plan.push_back('{uniform(sample_t'(SAMPLE_MAX)), 1'b0, RESULT_IDLE});
        plan.push_back('{uniform(sample_t'(SAMPLE_MAX)), 1'b1, RESULT_FULL});
        plan.push_back('{stripes(12'hAAA, 12'h555), 1'b0, RESULT_IDLE});
        plan.push_back('{stripes(12'h555, 12'hAAA), 1'b0, RESULT_IDLE});
        plan.push_back('{stripes(sample_t'(SAMPLE_MAX), 12'h001), 1'b0, RESULT_IDLE});
        plan.push_back('{uniform(12'h001), 1'b0, RESULT_IDLE});
        for (int i = 0; i < WINDOW - 1; i++)
            plan.push_back('{uniform('0), 1'b0, RESULT_IDLE});
        plan.push_back('{uniform('0), 1'b1, RESULT_IDLE});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            drive_frame(plan[i].frame, plan[i].typed, plan[i].fixed_result);

        // Random runs: free noise, rail-to-rail flips, or held levels
        run_left = 0;
        run_kind = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (run_left == 0)
            begin
                run_kind = $urandom_range(0, 2);
                run_left = $urandom_range(5, 25);
                for (int c = 0; c < CHANNELS; c++)
                    levels[c] = sample_t'($urandom);
            end
            run_left--;
            for (int c = 0; c < CHANNELS; c++)
            begin
                case (run_kind)
                    0:       f[c] = sample_t'($urandom);
                    1:       f[c] = ($urandom_range(0, 1) == 1) ? sample_t'(SAMPLE_MAX) : '0;
                    default: f[c] = levels[c];
                endcase
            end
            if (n % 40 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            drive_frame(f, 1'b0, RESULT_IDLE);
        end
        samples_bus.valid <= 1'b0;

        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
design/mmas_pkg.sv
design/mmas_in_if.sv
design/mmas_out_if.sv
design/mmas_cell.sv
design/mmas_lane.sv
design/multichannel_moving_average_scaler.sv
dv/multichannel_moving_average_scaler_tb.sv
